// File: hw/rtl/ltcd_pkg.sv
// shared constants, codes and types for the lru tag cache directory
package ltcd_pkg;

   // field widths
   localparam int TAG_W   = 64;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 16;
   localparam int SLOT_W  = 6;
   localparam int FUNC_W  = 2;

   // default directory size
   localparam int NUM_SLOTS_DEFAULT = 36;

   // request function codes, anything else acts as a probe
   localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PROBE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FILL    = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } ltcd_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ltcd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } ltcd_status_type;

endpackage

// File: hw/rtl/ltcd_if.sv
// request and response channel interfaces

interface ltcd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ltcd_pkg::FUNC_W-1:0]  func;
   logic [ltcd_pkg::TAG_W-1:0]   tag;
   logic                         fetch_ok;

   modport source (output valid, func, tag, fetch_ok, input ready);
   modport sink   (input valid, func, tag, fetch_ok, output ready);
endinterface

interface ltcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         known;
   logic [ltcd_pkg::SLOT_W-1:0]  slot;
   logic [ltcd_pkg::CNT_W-1:0]   hit_total;
   logic [ltcd_pkg::CNT_W-1:0]   miss_total;

   modport source (output valid, hit, known, slot, hit_total, miss_total, input ready);
   modport sink   (input valid, hit, known, slot, hit_total, miss_total, output ready);
endinterface

// File: hw/rtl/ltcd_ctrl.sv
// controller state machine: accept, scan the slots, drain, commit
module ltcd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ltcd_pkg::ltcd_status_type status,
   output ltcd_pkg::ltcd_cmd_type    cmd
);

   ltcd_pkg::ltcd_state_type state_ff;
   ltcd_pkg::ltcd_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ltcd_pkg::ST_IDLE: begin
            if (req_valid) state_in = ltcd_pkg::ST_SCAN;
         end
         ltcd_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = ltcd_pkg::ST_DRAIN;
         end
         ltcd_pkg::ST_DRAIN: begin
            state_in = ltcd_pkg::ST_COMMIT;
         end
         ltcd_pkg::ST_COMMIT: begin
            if (status.out_free) state_in = ltcd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ltcd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ltcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ltcd_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ltcd_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         ltcd_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/ltcd_datapath.sv
// datapath: slot memory, scan compare stage, counters and response register
module ltcd_datapath #(
   parameter int NUM_SLOTS = ltcd_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ltcd_pkg::ltcd_cmd_type       cmd,
   output ltcd_pkg::ltcd_status_type    status,
   input  logic [ltcd_pkg::FUNC_W-1:0]  req_func,
   input  logic [ltcd_pkg::TAG_W-1:0]   req_tag,
   input  logic                         req_fetch_ok,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic                         rsp_known,
   output logic [ltcd_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [ltcd_pkg::CNT_W-1:0]   rsp_hit_total,
   output logic [ltcd_pkg::CNT_W-1:0]   rsp_miss_total
);

   localparam int TAG_W   = ltcd_pkg::TAG_W;
   localparam int STAMP_W = ltcd_pkg::STAMP_W;
   localparam int CNT_W   = ltcd_pkg::CNT_W;
   localparam int SLOT_W  = ltcd_pkg::SLOT_W;
   localparam int FUNC_W  = ltcd_pkg::FUNC_W;
   localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WORD_W  = 1 + STAMP_W + TAG_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   // captured transaction
   logic [FUNC_W-1:0]  func_ff;
   logic [TAG_W-1:0]   key_ff;
   logic               ok_ff;

   // slot memory: {failed, stamp, tag}, plus per-slot written bits
   logic [WORD_W-1:0]    mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] written_ff;
   logic [NUM_SLOTS-1:0] written_in;

   // scan address and read stage
   logic [IDX_W-1:0]  scan_idx_ff;
   logic [IDX_W-1:0]  scan_idx_in;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_written_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_live_ff;

   // scan results
   logic               found_ff;
   logic               found_in;
   logic [IDX_W-1:0]   found_idx_ff;
   logic [IDX_W-1:0]   found_idx_in;
   logic               found_failed_ff;
   logic               found_failed_in;
   logic               empty_ff;
   logic               empty_in;
   logic [IDX_W-1:0]   empty_idx_ff;
   logic [IDX_W-1:0]   empty_idx_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [IDX_W-1:0]   best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [STAMP_W-1:0] best_stamp_in;

   // persistent state
   logic [STAMP_W-1:0] use_clock_ff;
   logic [STAMP_W-1:0] use_clock_in;
   logic [CNT_W-1:0]   hit_cnt_ff;
   logic [CNT_W-1:0]   hit_cnt_in;
   logic [CNT_W-1:0]   miss_cnt_ff;
   logic [CNT_W-1:0]   miss_cnt_in;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_hit_ff;
   logic               rsp_known_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   // compare stage signals
   logic [TAG_W-1:0]   ent_tag;
   logic [STAMP_W-1:0] ent_stamp;
   logic               ent_failed;
   logic               ent_empty;
   logic               ent_match;

   // commit signals
   logic               key_zero;
   logic               is_resolve;
   logic               is_fill;
   logic               res_hit;
   logic               res_miss;
   logic [IDX_W-1:0]   victim;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_word;
   logic [STAMP_W-1:0] next_stamp;
   logic [IDX_W-1:0]   slot_idx;

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= req_tag;
         ok_ff   <= req_fetch_ok;
      end
   end

   // slot memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_word_ff    <= mem[scan_idx_ff];
      rd_written_ff <= written_ff[scan_idx_ff];
      rd_idx_ff     <= scan_idx_ff;
   end

   // scan address
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
      end else if (cmd.scan && scan_idx_ff != LAST_IDX) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
   end

   // unwritten slots read as empty with stamp zero
   always_comb begin
      ent_tag    = rd_written_ff ? rd_word_ff[TAG_W-1:0] : '0;
      ent_stamp  = rd_written_ff ? rd_word_ff[TAG_W +: STAMP_W] : '0;
      ent_failed = rd_written_ff & rd_word_ff[WORD_W-1];
      ent_empty  = (ent_tag == '0);
      ent_match  = !ent_empty && (ent_tag == key_ff);
   end

   // lowest match, first empty, lowest stamp with earliest index
   always_comb begin
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_failed_in = found_failed_ff;
      empty_in        = empty_ff;
      empty_idx_in    = empty_idx_ff;
      best_idx_in     = best_idx_ff;
      best_stamp_in   = best_stamp_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         empty_in = 1'b0;
      end else if (rd_live_ff) begin
         if (!found_ff && ent_match) begin
            found_in        = 1'b1;
            found_idx_in    = rd_idx_ff;
            found_failed_in = ent_failed;
         end
         if (!empty_ff && ent_empty) begin
            empty_in     = 1'b1;
            empty_idx_in = rd_idx_ff;
         end
         if (rd_idx_ff == '0 || ent_stamp < best_stamp_ff) begin
            best_idx_in   = rd_idx_ff;
            best_stamp_in = ent_stamp;
         end
      end
   end

   // commit decode and memory update
   always_comb begin
      key_zero   = (key_ff == '0);
      is_resolve = (func_ff == ltcd_pkg::FUNC_RESOLVE);
      is_fill    = (func_ff == ltcd_pkg::FUNC_FILL);
      res_hit    = is_resolve && !key_zero && found_ff && !found_failed_ff;
      res_miss   = is_resolve && !key_zero && !res_hit;
      victim     = empty_ff ? empty_idx_ff : best_idx_ff;
      next_stamp = use_clock_ff + STAMP_W'(1);
      wr_en      = cmd.commit && (res_hit || is_fill);
      wr_addr    = res_hit ? found_idx_ff : victim;
      wr_word    = {is_fill & ~ok_ff, next_stamp, key_ff};
      if (res_hit) begin
         slot_idx = found_idx_ff;
      end else if (is_fill) begin
         slot_idx = victim;
      end else begin
         slot_idx = '0;
      end
   end

   // persistent state next values
   always_comb begin
      written_in   = written_ff;
      use_clock_in = use_clock_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
         use_clock_in        = next_stamp;
      end
      if (cmd.commit && res_hit) hit_cnt_in = hit_cnt_ff + CNT_W'(1);
      if (cmd.commit && res_miss) miss_cnt_in = miss_cnt_ff + CNT_W'(1);
   end

   // response valid: set on commit, cleared when taken
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         scan_idx_ff  <= '0;
         rd_live_ff   <= 1'b0;
         found_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         use_clock_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         scan_idx_ff  <= scan_idx_in;
         rd_live_ff   <= cmd.scan;
         found_ff     <= found_in;
         empty_ff     <= empty_in;
         use_clock_ff <= use_clock_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan payload registers
   always_ff @(posedge clock) begin
      found_idx_ff    <= found_idx_in;
      found_failed_ff <= found_failed_in;
      empty_idx_ff    <= empty_idx_in;
      best_idx_ff     <= best_idx_in;
      best_stamp_ff   <= best_stamp_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff   <= res_hit;
         rsp_known_ff <= key_zero | found_ff;
         rsp_slot_ff  <= SLOT_W'(slot_idx);
      end
   end

   // status and outputs
   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_known      = rsp_known_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_hit_total  = hit_cnt_ff;
   assign rsp_miss_total = miss_cnt_ff;

endmodule

// File: hw/rtl/lru_tag_cache_directory_top.sv
// A transaction accepted in idle is scanned one slot per cycle through the single-read-port slot memory,
// then passes a drain state and a commit state; commit waits while the output register still holds
// an untaken response, so a new transaction is accepted only after the last one has committed.
// A finished response waits in an output register while the next request is accepted.
// Reset: synchronous, active high; clears all slots to empty, stamps, use clock and counters.
module lru_tag_cache_directory_top #(
   parameter int NUM_SLOTS = ltcd_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ltcd_req_if.sink   req,
   ltcd_rsp_if.source rsp
);

   ltcd_pkg::ltcd_cmd_type    cmd;
   ltcd_pkg::ltcd_status_type status;

   // sequencing
   ltcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot storage and result logic
   ltcd_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req.func),
      .req_tag        (req.tag),
      .req_fetch_ok   (req.fetch_ok),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_hit        (rsp.hit),
      .rsp_known      (rsp.known),
      .rsp_slot       (rsp.slot),
      .rsp_hit_total  (rsp.hit_total),
      .rsp_miss_total (rsp.miss_total)
   );

endmodule

// File: hw/rtl/ltcd_checker.sv
// port-level checker for the directory, bound to the top level
module ltcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic                         rsp_known,
   input logic [ltcd_pkg::SLOT_W-1:0]  rsp_slot,
   input logic [ltcd_pkg::CNT_W-1:0]   rsp_hit_total
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its slot and hit total
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_slot) && $stable(rsp_hit_total))
      else $error("response payload changed while stalled");

   // one transaction in flight: no request taken right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during a scan");

   // a hit always reports a known key
   a_hit_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_known)
      else $error("hit reported for an unknown key");

endmodule

bind lru_tag_cache_directory_top ltcd_checker u_ltcd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_hit       (rsp.hit),
   .rsp_known     (rsp.known),
   .rsp_slot      (rsp.slot),
   .rsp_hit_total (rsp.hit_total)
);
